// File: src/pfsp_pkg.sv
// pfsp_pkg: shared types and character codes for the printf conversion specifier parser
`default_nettype none

package pfsp_pkg;

    localparam logic [7:0] C_NUL    = 8'd0;
    localparam logic [7:0] C_SPACE  = 8'd32;
    localparam logic [7:0] C_MINUS  = 8'd45;
    localparam logic [7:0] C_ZERO   = 8'd48;
    localparam logic [7:0] C_NINE   = 8'd57;
    localparam logic [7:0] C_HASH   = 8'd35;
    localparam logic [7:0] C_PLUS   = 8'd43;
    localparam logic [7:0] C_STAR   = 8'd42;
    localparam logic [7:0] C_DOT    = 8'd46;
    localparam logic [7:0] C_LOW_L  = 8'd108;
    localparam logic [7:0] C_LOW_H  = 8'd104;
    localparam logic [7:0] C_UP_L   = 8'd76;

    localparam logic [30:0] SAT_MAX = 31'h7FFF_FFFF;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_H    = 3'd1;
    localparam logic [2:0] LEN_HH   = 3'd2;
    localparam logic [2:0] LEN_L    = 3'd3;
    localparam logic [2:0] LEN_LL   = 3'd4;
    localparam logic [2:0] LEN_BIGL = 3'd5;

    localparam int FLAG_SPACE = 0;
    localparam int FLAG_LEFT  = 1;
    localparam int FLAG_ZERO  = 2;
    localparam int FLAG_HASH  = 3;
    localparam int FLAG_PLUS  = 4;

    typedef enum logic [2:0] {
        PH_FLAGS = 3'd0,
        PH_WIDTH = 3'd1,
        PH_DOT   = 3'd2,
        PH_PREC  = 3'd3,
        PH_LEN   = 3'd4,
        PH_L1    = 3'd5,
        PH_H1    = 3'd6,
        PH_TYPE  = 3'd7
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic        [4:0]  flags;
        logic        [30:0] width;
        logic signed [31:0] prec;
        logic        [2:0]  length;
    } t_state;

    typedef struct packed {
        logic               ended_early;
        logic        [7:0]  type_char;
        logic        [2:0]  length_mod;
        logic signed [31:0] prec_value;
        logic        [30:0] field_width;
        logic               flag_plus;
        logic               flag_hash;
        logic               flag_zero;
        logic               flag_left;
        logic               flag_space;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:  PH_FLAGS,
        flags:  5'd0,
        width:  31'd0,
        prec:   -32'sd1,
        length: LEN_NONE
    };

endpackage

`default_nettype wire

// File: src/pfsp_step.sv
// pfsp_step: next parser state and result for one character
`default_nettype none

module pfsp_step
    import pfsp_pkg::*;
(
    input  wire t_state        i_state,
    input  wire logic [7:0]    i_ch,
    input  wire logic [31:0]   i_star_arg,
    output t_state             o_state,
    output logic               o_emit,
    output t_result            o_result
);

    function automatic logic [30:0] acc_digit(input logic [30:0] acc, input logic [3:0] d);
        logic [34:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, d};
        return (v > {4'd0, SAT_MAX}) ? SAT_MAX : v[30:0];
    endfunction

    logic        is_digit;
    logic        is_flag;
    logic [3:0]  digit;
    logic [4:0]  flag_set;
    logic [31:0] mag;
    logic [30:0] star_width;
    logic        go_len;
    t_state      n_st;

    assign is_digit = (i_ch >= C_ZERO) && (i_ch <= C_NINE);
    assign digit    = 4'(i_ch - C_ZERO);
    assign mag      = 32'd0 - i_star_arg;

    always_comb begin
        flag_set = 5'd0;
        unique case (i_ch)
            C_SPACE: flag_set[FLAG_SPACE] = 1'b1;
            C_MINUS: flag_set[FLAG_LEFT]  = 1'b1;
            C_ZERO:  flag_set[FLAG_ZERO]  = 1'b1;
            C_HASH:  flag_set[FLAG_HASH]  = 1'b1;
            C_PLUS:  flag_set[FLAG_PLUS]  = 1'b1;
            default: flag_set = 5'd0;
        endcase
        is_flag = |flag_set;
    end

    always_comb begin
        if (i_star_arg[31]) begin
            star_width = mag[31] ? SAT_MAX : mag[30:0];
        end else begin
            star_width = i_star_arg[30:0];
        end
    end

    always_comb begin
        n_st   = i_state;
        go_len = 1'b0;
        o_emit = 1'b0;
        unique case (i_state.phase)
            PH_FLAGS, PH_WIDTH: begin
                if (i_state.phase == PH_FLAGS && is_flag) begin
                    n_st.flags = i_state.flags | flag_set;
                end else if (is_digit) begin
                    n_st.width = acc_digit(i_state.width, digit);
                    n_st.phase = PH_WIDTH;
                end else if (i_ch == C_STAR) begin
                    n_st.width = star_width;
                    if (i_star_arg[31]) begin
                        n_st.flags[FLAG_LEFT] = 1'b1;
                    end
                    n_st.phase = PH_DOT;
                end else if (i_ch == C_DOT) begin
                    n_st.prec  = 32'sd0;
                    n_st.phase = PH_PREC;
                end else begin
                    go_len = 1'b1;
                end
            end
            PH_DOT: begin
                if (i_ch == C_DOT) begin
                    n_st.prec  = 32'sd0;
                    n_st.phase = PH_PREC;
                end else begin
                    go_len = 1'b1;
                end
            end
            PH_PREC: begin
                if (is_digit) begin
                    n_st.prec = $signed({1'b0, acc_digit(i_state.prec[30:0], digit)});
                end else if (i_ch == C_STAR) begin
                    n_st.prec  = i_star_arg[31] ? -32'sd1 : $signed(i_star_arg);
                    n_st.phase = PH_LEN;
                end else begin
                    go_len = 1'b1;
                end
            end
            PH_LEN: go_len = 1'b1;
            PH_L1: begin
                if (i_ch == C_LOW_L) begin
                    n_st.length = LEN_LL;
                    n_st.phase  = PH_TYPE;
                end else begin
                    n_st.length = LEN_L;
                    o_emit      = 1'b1;
                end
            end
            PH_H1: begin
                if (i_ch == C_LOW_H) begin
                    n_st.length = LEN_HH;
                    n_st.phase  = PH_TYPE;
                end else begin
                    n_st.length = LEN_H;
                    o_emit      = 1'b1;
                end
            end
            PH_TYPE: o_emit = 1'b1;
        endcase

        if (go_len) begin
            priority if (i_ch == C_LOW_L) begin
                n_st.phase = PH_L1;
            end else if (i_ch == C_LOW_H) begin
                n_st.phase = PH_H1;
            end else if (i_ch == C_UP_L) begin
                n_st.length = LEN_BIGL;
                n_st.phase  = PH_TYPE;
            end else begin
                o_emit = 1'b1;
            end
        end

        o_result.flag_space  = n_st.flags[FLAG_SPACE];
        o_result.flag_left   = n_st.flags[FLAG_LEFT];
        o_result.flag_zero   = n_st.flags[FLAG_ZERO] & ~n_st.flags[FLAG_LEFT];
        o_result.flag_hash   = n_st.flags[FLAG_HASH];
        o_result.flag_plus   = n_st.flags[FLAG_PLUS];
        o_result.field_width = n_st.width;
        o_result.prec_value  = n_st.prec;
        o_result.length_mod  = n_st.length;
        o_result.type_char   = i_ch;
        o_result.ended_early = (i_ch == C_NUL);

        o_state = o_emit ? STATE_RESET : n_st;
    end

endmodule

`default_nettype wire

// File: src/printf_format_spec_parser.sv
// printf_format_spec_parser: top level, parser state register and result register
//
// channel   dir  width  contents
// s_axis    in   40     ch, star_arg
// m_axis    out  80+1   parsed specifier fields, tuser ended_early
//
// one character is taken per cycle unless an output stall holds the input; each transfer updates the parser state
// a type character or nul registers one result, valid in the cycle after it is taken
// input is taken whenever the result register is empty or being drained
// reset is synchronous, active low, and returns the parser to the flags phase
// output stalls hold the result register and back-pressure the input only then
`default_nettype none

module printf_format_spec_parser
    import pfsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,   // ch[7:0], star_arg[39:8]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [79:0]      o_m_axis_tdata,   // flag_space, flag_left, flag_zero,
                                               // flag_hash, flag_plus, field_width[35:5],
                                               // prec_value[67:36], length_mod[70:68],
                                               // type_char[78:71], zero pad
    output logic [0:0]       o_m_axis_tuser    // ended_early
);

    t_state  r_state;
    t_state  n_state;
    logic    step_emit;
    t_result step_result;
    logic    r_out_valid;
    t_result r_out;
    logic    in_xfer;

    pfsp_step u_step (
        .i_state    (r_state),
        .i_ch       (i_s_axis_tdata[7:0]),
        .i_star_arg (i_s_axis_tdata[39:8]),
        .o_state    (n_state),
        .o_emit     (step_emit),
        .o_result   (step_result)
    );

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_state <= n_state;
            end
            if (in_xfer) begin
                r_out_valid <= step_emit;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && step_emit) begin
            r_out <= step_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.ended_early;
    assign o_m_axis_tdata  = {1'b0, r_out.type_char, r_out.length_mod, r_out.prec_value,
                              r_out.field_width, r_out.flag_plus, r_out.flag_hash,
                              r_out.flag_zero, r_out.flag_left, r_out.flag_space};

    a_end_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser[0] == (r_out.type_char == C_NUL)))
        else $error("ended_early does not match type character");

    a_left_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(r_out.flag_left && r_out.flag_zero))
        else $error("left justify and zero padding both set");

    a_prec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.prec == -32'sd1 || !r_state.prec[31])
        else $error("precision below minus one");

    a_emit_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && step_emit) |=> (r_state == STATE_RESET && r_out_valid))
        else $error("parser not back in reset state after result");

    a_stall_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while result is stalled");

endmodule

`default_nettype wire

// File: sim/printf_format_spec_parser_check.sv
// checker for printf_format_spec_parser: predicts parsed specifiers and compares result transfers
`timescale 1ns / 1ps

module printf_format_spec_parser_check
    import pfsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [39:0] i_s_tdata,    // ch, star_arg
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [79:0] i_m_tdata,    // flags, field_width, prec_value, length_mod, type_char
    input  wire logic [0:0]  i_m_tuser,    // ended_early
    output int               o_errors,
    output int               o_pending
);

    t_state  spec;
    t_result spec_due[$];
    t_result seen;
    t_result want;

    initial begin
        spec      = STATE_RESET;
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= C_ZERO) && (c <= C_NINE);
    endfunction

    function automatic logic [30:0] times_ten_sat(input logic [30:0] acc, input logic [7:0] c);
        logic [63:0] v;
        v = {33'd0, acc} * 64'd10 + {56'd0, c - C_ZERO};
        return (v > {33'd0, SAT_MAX}) ? SAT_MAX : v[30:0];
    endfunction

    task automatic parse_char(input logic [7:0] c, input logic [31:0] arg);
        logic        taken;
        logic        done;
        logic [31:0] mag;
        t_result     r;
        taken = 1'b0;
        done  = 1'b0;
        if (spec.phase == PH_FLAGS) begin
            taken = 1'b1;
            case (c)
                C_SPACE: spec.flags[FLAG_SPACE] = 1'b1;
                C_MINUS: spec.flags[FLAG_LEFT]  = 1'b1;
                C_ZERO:  spec.flags[FLAG_ZERO]  = 1'b1;
                C_HASH:  spec.flags[FLAG_HASH]  = 1'b1;
                C_PLUS:  spec.flags[FLAG_PLUS]  = 1'b1;
                default: taken = 1'b0;
            endcase
        end
        if (!taken && (spec.phase == PH_FLAGS || spec.phase == PH_WIDTH)) begin
            if (is_digit(c)) begin
                spec.width = times_ten_sat(spec.width, c);
                spec.phase = PH_WIDTH;
                taken      = 1'b1;
            end else if (c == C_STAR) begin
                if (arg[31]) begin
                    // magnitude of a negative width, most negative saturates
                    mag                   = -arg;
                    spec.width            = mag[31] ? SAT_MAX : mag[30:0];
                    spec.flags[FLAG_LEFT] = 1'b1;
                end else begin
                    spec.width = arg[30:0];
                end
                spec.phase = PH_DOT;
                taken      = 1'b1;
            end
        end
        if (!taken && c == C_DOT &&
            (spec.phase == PH_FLAGS || spec.phase == PH_WIDTH || spec.phase == PH_DOT)) begin
            spec.prec  = 32'sd0;
            spec.phase = PH_PREC;
            taken      = 1'b1;
        end
        if (!taken && spec.phase == PH_PREC) begin
            if (is_digit(c)) begin
                spec.prec = $signed({1'b0, times_ten_sat(spec.prec[30:0], c)});
                taken     = 1'b1;
            end else if (c == C_STAR) begin
                spec.prec  = arg[31] ? -32'sd1 : $signed(arg);
                spec.phase = PH_LEN;
                taken      = 1'b1;
            end
        end
        if (!taken) begin
            case (spec.phase)
                PH_L1: begin
                    if (c == C_LOW_L) begin
                        spec.length = LEN_LL;
                        spec.phase  = PH_TYPE;
                    end else begin
                        spec.length = LEN_L;
                        done        = 1'b1;
                    end
                end
                PH_H1: begin
                    if (c == C_LOW_H) begin
                        spec.length = LEN_HH;
                        spec.phase  = PH_TYPE;
                    end else begin
                        spec.length = LEN_H;
                        done        = 1'b1;
                    end
                end
                PH_TYPE: done = 1'b1;
                default: begin
                    if (c == C_LOW_L) begin
                        spec.phase = PH_L1;
                    end else if (c == C_LOW_H) begin
                        spec.phase = PH_H1;
                    end else if (c == C_UP_L) begin
                        spec.length = LEN_BIGL;
                        spec.phase  = PH_TYPE;
                    end else begin
                        done = 1'b1;
                    end
                end
            endcase
        end
        if (done) begin
            r.flag_space  = spec.flags[FLAG_SPACE];
            r.flag_left   = spec.flags[FLAG_LEFT];
            r.flag_zero   = spec.flags[FLAG_LEFT] ? 1'b0 : spec.flags[FLAG_ZERO];
            r.flag_hash   = spec.flags[FLAG_HASH];
            r.flag_plus   = spec.flags[FLAG_PLUS];
            r.field_width = spec.width;
            r.prec_value  = spec.prec;
            r.length_mod  = spec.length;
            r.type_char   = c;
            r.ended_early = (c == C_NUL);
            spec_due.push_back(r);
            spec          = STATE_RESET;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s expected 'h%0h got 'h%0h", $time, name, exp_v, got_v);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            spec = STATE_RESET;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen = {i_m_tuser, i_m_tdata[78:0]};
                if (spec_due.size() == 0) begin
                    $display("%0t: result transfer with none expected, got 'h%0h",
                             $time, seen);
                    o_errors++;
                end else begin
                    want = spec_due.pop_front();
                    check_field("flag_space", 32'(want.flag_space), 32'(seen.flag_space));
                    check_field("flag_left", 32'(want.flag_left), 32'(seen.flag_left));
                    check_field("flag_zero", 32'(want.flag_zero), 32'(seen.flag_zero));
                    check_field("flag_hash", 32'(want.flag_hash), 32'(seen.flag_hash));
                    check_field("flag_plus", 32'(want.flag_plus), 32'(seen.flag_plus));
                    check_field("field_width", 32'(want.field_width),
                                32'(seen.field_width));
                    check_field("prec_value", want.prec_value, seen.prec_value);
                    check_field("length_mod", 32'(want.length_mod), 32'(seen.length_mod));
                    check_field("type_char", 32'(want.type_char), 32'(seen.type_char));
                    check_field("ended_early", 32'(want.ended_early),
                                32'(seen.ended_early));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                parse_char(i_s_tdata[7:0], i_s_tdata[39:8]);
            end
        end
        o_pending = spec_due.size();
    end

endmodule

// File: sim/printf_format_spec_parser_test.sv
// testbench top for printf_format_spec_parser: format character stimulus, output stalls, verdict
`timescale 1ns / 1ps

module printf_format_spec_parser_test;
    import pfsp_pkg::*;

    localparam int CHAR_GOAL   = 900;
    localparam int STUCK_LIMIT = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [39:0] s_data;       // ch[7:0], star_arg[39:8]
    logic        m_valid;
    logic        m_ready;
    logic [79:0] m_data;       // flags[4:0], field_width, prec_value, length_mod, type_char
    logic [0:0]  m_user;       // ended_early
    int          errors;
    int          pending;
    int          stuck;
    int          queued;
    logic        src_steady;
    logic        sink_busy;
    int          sink_left;
    logic [39:0] char_q[$];

    printf_format_spec_parser DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    printf_format_spec_parser_check spec_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .i_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .i_m_tdata  (m_data),
        .i_m_tuser  (m_user),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial stuck = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck <= 0;
        end else begin
            stuck <= stuck + 1;
        end
        if (stuck == STUCK_LIMIT) begin
            $display("[printf_format_spec_parser] ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) return $urandom_range(1, 3);
        if (r < 19) return $urandom_range(4, 9);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_arg();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return $urandom_range(0, 99);
            5:       return -$urandom_range(1, 99);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_flag();
        case ($urandom_range(0, 4))
            0:       return C_SPACE;
            1:       return C_MINUS;
            2:       return C_ZERO;
            3:       return C_HASH;
            default: return C_PLUS;
        endcase
    endfunction

    // sink side: stretches of ready mixed with short and occasional long stalls
    initial begin
        m_ready   = 1'b0;
        sink_busy = 1'b0;
        sink_left = 0;
        forever begin
            @(negedge i_clk);
            if (sink_left == 0) begin
                sink_busy = ($urandom_range(0, 2) == 0);
                sink_left = sink_busy ? pick_gap() : $urandom_range(1, 40);
            end
            m_ready = !sink_busy;
            sink_left--;
        end
    end

    task automatic add_ch(input logic [7:0] c, input logic [31:0] a);
        char_q.push_back({a, c});
        queued++;
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) add_ch(s[i], $urandom);
    endtask

    task automatic add_digits(input int n);
        repeat (n) add_ch(C_ZERO + 8'($urandom_range(0, 9)), $urandom);
    endtask

    task automatic add_random_spec();
        string conv;
        conv = "diouxXcspfegn%";
        if ($urandom_range(0, 9) == 0) begin
            // noise: arbitrary bytes, nul included
            repeat ($urandom_range(1, 4)) add_ch(8'($urandom_range(0, 255)), $urandom);
        end else begin
            repeat ($urandom_range(0, 3)) add_ch(pick_flag(), $urandom);
            case ($urandom_range(0, 6))
                2, 3: add_digits($urandom_range(1, 3));
                4:    add_digits($urandom_range(10, 12));
                5:    add_ch(C_STAR, pick_arg());
                6: begin
                    add_digits($urandom_range(1, 3));
                    add_ch(C_STAR, pick_arg());
                end
                default: ;
            endcase
            case ($urandom_range(0, 6))
                2: add_ch(C_DOT, $urandom);
                3: begin
                    add_ch(C_DOT, $urandom);
                    add_digits($urandom_range(1, 3));
                end
                4: begin
                    add_ch(C_DOT, $urandom);
                    add_digits($urandom_range(10, 12));
                end
                5: begin
                    add_ch(C_DOT, $urandom);
                    add_ch(C_STAR, pick_arg());
                end
                6: begin
                    add_ch(C_DOT, $urandom);
                    add_digits($urandom_range(1, 2));
                    add_ch(C_STAR, pick_arg());
                end
                default: ;
            endcase
            case ($urandom_range(0, 7))
                1: add_str("h");
                2: add_str("hh");
                3: add_str("l");
                4: add_str("ll");
                5: add_str("L");
                default: ;
            endcase
            case ($urandom_range(0, 11))
                0:       add_ch(C_NUL, $urandom);
                1:       add_ch(8'($urandom_range(1, 255)), $urandom);
                default: add_ch(conv[$urandom_range(0, conv.len() - 1)], $urandom);
            endcase
        end
    endtask

    task automatic send_queued();
        while (char_q.size() != 0) begin
            if (!src_steady && $urandom_range(0, 2) == 0) begin
                s_valid = 1'b0;
                repeat (pick_gap()) @(negedge i_clk);
            end
            s_valid = 1'b1;
            s_data  = char_q.pop_front();
            do @(posedge i_clk); while (!s_ready);
            @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        s_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n    = 1'b0;
        s_valid    = 1'b0;
        s_data     = 40'd0;
        queued     = 0;
        src_steady = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // all flags, width and precision digits, ll
        add_str(" -0#+1.2lli");
        // most negative star width, negative star precision, hh
        add_ch(C_STAR, 32'h8000_0000);
        add_ch(C_DOT, $urandom);
        add_ch(C_STAR, -32'sd7);
        add_str("hhu");
        // zero flag kept, star after digits, dot without digits, L
        add_str("07");
        add_ch(C_STAR, 32'h7FFF_FFFF);
        add_str(".Lf");
        // h followed by l takes l as the type
        add_str("hl");
        // nul after a single l
        add_str("l");
        add_ch(C_NUL, 32'hFFFF_FFFF);
        add_ch(8'hFF, 32'hFFFF_FFFF);
        send_queued();
        drain_results();

        while (queued < CHAR_GOAL) begin
            src_steady = ($urandom_range(0, 4) == 0);
            add_random_spec();
            send_queued();
            if ($urandom_range(0, 39) == 0) drain_results();
        end

        drain_results();
        repeat (8) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("[printf_format_spec_parser] OK");
        end else begin
            $display("[printf_format_spec_parser] ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/pfsp_pkg.sv
src/pfsp_step.sv
src/printf_format_spec_parser.sv
sim/printf_format_spec_parser_check.sv
sim/printf_format_spec_parser_test.sv
